@@ hdl/ppprx_pkg.sv @@
package ppprx_pkg;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_XOR   = 8'h20;
   localparam logic [7:0]  ADDR_BYTE = 8'hFF;
   localparam logic [7:0]  CTRL_BYTE = 8'h03;
   localparam logic [7:0]  PROTO_PAD = 8'h00;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_GOOD  = 16'hF0B8;
   localparam logic [15:0] CRC_POLY  = 16'h8408;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic        kind;
      logic [7:0]  byte_value;
      logic [7:0]  position;
      logic        frame_ok;
      logic [15:0] protocol;
      logic        last;
   } rslt_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] v;
      v = {8'h00, b ^ crc[7:0]};
      for (int i = 0; i < 8; i++) begin
         if (v[0]) begin
            v = (v >> 1) ^ CRC_POLY;
         end else begin
            v = v >> 1;
         end
      end
      return v ^ {8'h00, crc[15:8]};
   endfunction

endpackage

@@ hdl/ppp_rx_deframer.sv @@
// An accepted byte is registered in the input register, then decoded into the result queue.
// Throughput: one byte per cycle while rsp_stall is low and each byte gives one beat at most.
// A byte that re-inserts omitted header bytes gives up to four result beats, one per
// unstalled cycle, from a four-entry queue; the next byte is decoded as the last one leaves.
// Reset is synchronous and active high; it clears the count, escape flag and protocol bytes,
// sets the CRC to 0xFFFF and empties the input register and the result queue.
module ppp_rx_deframer #(
   parameter int unsigned BUFFER_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [7:0]  rsp_position,
   output logic        rsp_frame_ok,
   output logic [15:0] rsp_protocol,
   output logic        rsp_last
);
   import ppprx_pkg::*;

   localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
   localparam int unsigned PW = CW + 8;
   localparam int unsigned QW = $clog2(QUEUE_DEPTH + 1);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [15:0]       crc_ff, crc_in;
   logic              esc_ff, esc_in;
   logic [7:0]        proto_high_ff, proto_high_in;
   logic [7:0]        proto_low_ff, proto_low_in;
   rslt_type          queue_ff [QUEUE_DEPTH];
   rslt_type          queue_in [QUEUE_DEPTH];
   logic [QW-1:0]     qcnt_ff, qcnt_in;

   logic              pop;
   logic              load;
   logic              accept;
   logic              is_flag;
   logic              is_esc;
   logic [7:0]        data_byte;
   logic              cand_en  [QUEUE_DEPTH];
   logic [7:0]        cand_val [QUEUE_DEPTH];
   logic [CW-1:0]     cand_pos [QUEUE_DEPTH];
   rslt_type          slot     [QUEUE_DEPTH];
   logic [QW-1:0]     nres;

   assign pop       = (qcnt_ff != '0) && !rsp_stall;
   assign load      = in_valid_ff && ((qcnt_ff == '0) || ((qcnt_ff == QW'(1)) && pop));
   assign req_stall = in_valid_ff && !load;
   assign accept    = req_valid && !req_stall;

   assign is_flag   = (in_byte_ff == FLAG_BYTE);
   assign is_esc    = (in_byte_ff == ESC_BYTE);
   assign data_byte = esc_ff ? (in_byte_ff ^ ESC_XOR) : in_byte_ff;

   always_comb begin
      logic [CW-1:0] c;
      logic [PW-1:0] ext;
      c           = count_ff;
      ext         = '0;
      cand_en[0]  = (c == '0) && (data_byte != ADDR_BYTE);
      cand_val[0] = ADDR_BYTE;
      cand_pos[0] = c;
      c           = c + CW'(cand_en[0]);
      cand_en[1]  = (c == CW'(1)) && (data_byte != CTRL_BYTE);
      cand_val[1] = CTRL_BYTE;
      cand_pos[1] = c;
      c           = c + CW'(cand_en[1]);
      cand_en[2]  = (c == CW'(2)) && data_byte[0];
      cand_val[2] = PROTO_PAD;
      cand_pos[2] = c;
      c           = c + CW'(cand_en[2]);
      cand_en[3]  = (c < CW'(BUFFER_BYTES));
      cand_val[3] = data_byte;
      cand_pos[3] = c;
      c           = c + CW'(cand_en[3]);

      nres          = '0;
      proto_high_in = proto_high_ff;
      proto_low_in  = proto_low_ff;
      count_in      = count_ff;
      crc_in        = crc_ff;
      esc_in        = esc_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot[i] = '0;
      end

      if (is_flag) begin
         slot[0].kind     = KIND_END;
         slot[0].frame_ok = (count_ff != '0) && (crc_ff == CRC_GOOD);
         slot[0].protocol = {proto_high_ff, proto_low_ff};
         slot[0].last     = 1'b1;
         nres             = QW'(1);
         esc_in           = 1'b0;
         count_in         = '0;
         crc_in           = CRC_INIT;
      end else if (is_esc) begin
         esc_in = 1'b1;
      end else begin
         esc_in   = 1'b0;
         count_in = c;
         crc_in   = crc_step(crc_ff, data_byte);
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (cand_en[i]) begin
               ext                         = PW'(cand_pos[i]);
               slot[nres[1:0]].kind        = KIND_DATA;
               slot[nres[1:0]].byte_value  = cand_val[i];
               slot[nres[1:0]].position    = ext[7:0];
               if (cand_pos[i] == CW'(2)) begin
                  proto_high_in = cand_val[i];
               end
               if (cand_pos[i] == CW'(3)) begin
                  proto_low_in = cand_val[i];
               end
               nres = nres + QW'(1);
            end
         end
         if (nres != '0) begin
            slot[2'(nres - QW'(1))].last = 1'b1;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end

      qcnt_in = qcnt_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_in[i] = queue_ff[i];
      end
      if (load) begin
         qcnt_in = nres;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            queue_in[i] = slot[i];
         end
      end else if (pop) begin
         qcnt_in = qcnt_ff - QW'(1);
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            queue_in[i] = queue_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         count_ff      <= '0;
         crc_ff        <= CRC_INIT;
         esc_ff        <= 1'b0;
         proto_high_ff <= '0;
         proto_low_ff  <= '0;
         qcnt_ff       <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         qcnt_ff     <= qcnt_in;
         if (load) begin
            count_ff      <= count_in;
            crc_ff        <= crc_in;
            esc_ff        <= esc_in;
            proto_high_ff <= proto_high_in;
            proto_low_ff  <= proto_low_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   assign rsp_valid      = (qcnt_ff != '0);
   assign rsp_kind       = queue_ff[0].kind;
   assign rsp_byte_value = queue_ff[0].byte_value;
   assign rsp_position   = queue_ff[0].position;
   assign rsp_frame_ok   = queue_ff[0].frame_ok;
   assign rsp_protocol   = queue_ff[0].protocol;
   assign rsp_last       = queue_ff[0].last;

   // A beat that is not the last of its byte is always followed by the next buffer position.
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=>
         (rsp_valid && rsp_kind == KIND_DATA && rsp_position == $past(rsp_position) + 8'd1))
      else $error("result burst broken");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_END) |-> rsp_last)
      else $error("frame end not last beat");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(BUFFER_BYTES))
      else $error("byte count beyond buffer");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= QW'(QUEUE_DEPTH))
      else $error("result queue overflow");

endmodule

@@ dv/tb_ppp_rx_deframer.sv @@
`timescale 1ns / 1ps

module tb_ppp_rx_deframer;
   import ppprx_pkg::*;

   localparam int unsigned BUF_BYTES   = 256;
   localparam int unsigned RANDOM_BYTES = 480;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned REPORT_MAX  = 10;

   localparam logic [7:0] OPENING [14] = '{
      FLAG_BYTE, 8'h00, FLAG_BYTE, 8'h21, ADDR_BYTE, ESC_BYTE, ESC_BYTE, 8'h5E,
      ESC_BYTE, FLAG_BYTE, 8'h80, ESC_BYTE, 8'h5D, FLAG_BYTE
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_byte_value;
   logic [7:0]  rsp_position;
   logic        rsp_frame_ok;
   logic [15:0] rsp_protocol;
   logic        rsp_last;

   logic [7:0]  link_bytes [$];
   logic [7:0]  frame_body [$];
   rslt_type    step_beats [$];
   rslt_type    expected_beats [$];

   logic [8:0]  frame_len;
   logic [15:0] fcs_acc;
   logic        esc_armed;
   logic [7:0]  proto_hi;
   logic [7:0]  proto_lo;

   int unsigned total_bytes = 0;
   int unsigned bytes_accepted = 0;
   int unsigned beats_checked = 0;
   int unsigned frames_ended = 0;
   int unsigned frames_good = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap_pct = 10;
   int unsigned stall_pct = 63;

   ppp_rx_deframer #(
      .BUFFER_BYTES(BUF_BYTES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_byte_value(rsp_byte_value),
      .rsp_position(rsp_position),
      .rsp_frame_ok(rsp_frame_ok),
      .rsp_protocol(rsp_protocol),
      .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] fcs16_next(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] r;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ d[i]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   function automatic void clear_decoder();
      frame_len = '0;
      fcs_acc   = CRC_INIT;
      esc_armed = 1'b0;
      proto_hi  = 8'h00;
      proto_lo  = 8'h00;
   endfunction

   function automatic void keep_byte(input logic [7:0] b);
      rslt_type r;
      if (frame_len < BUF_BYTES) begin
         if (frame_len == 2) begin
            proto_hi = b;
         end else if (frame_len == 3) begin
            proto_lo = b;
         end
         r = '0;
         r.kind = KIND_DATA;
         r.byte_value = b;
         r.position = frame_len[7:0];
         step_beats.push_back(r);
         frame_len = frame_len + 1'b1;
      end
   endfunction

   function automatic void decode_link_byte(input logic [7:0] raw);
      logic [7:0] c;
      rslt_type   r;
      step_beats.delete();
      c = raw;
      if (raw == FLAG_BYTE) begin
         r = '0;
         r.kind = KIND_END;
         r.frame_ok = (frame_len != 0) && (fcs_acc == CRC_GOOD);
         r.protocol = {proto_hi, proto_lo};
         step_beats.push_back(r);
         esc_armed = 1'b0;
         frame_len = '0;
         fcs_acc = CRC_INIT;
      end else if (raw == ESC_BYTE) begin
         esc_armed = 1'b1;
      end else begin
         if (esc_armed) begin
            c = raw ^ ESC_XOR;
            esc_armed = 1'b0;
         end
         if (frame_len == 0 && c != ADDR_BYTE) begin
            keep_byte(ADDR_BYTE);
         end
         if (frame_len == 1 && c != CTRL_BYTE) begin
            keep_byte(CTRL_BYTE);
         end
         if (frame_len == 2 && c[0]) begin
            keep_byte(PROTO_PAD);
         end
         keep_byte(c);
         fcs_acc = fcs16_next(fcs_acc, c);
      end
      foreach (step_beats[i]) begin
         r = step_beats[i];
         r.last = (i == step_beats.size() - 1);
         expected_beats.push_back(r);
      end
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(11))
         0: return FLAG_BYTE;
         1: return ESC_BYTE;
         2: return ADDR_BYTE;
         3: return CTRL_BYTE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic void build_body(input int unsigned len);
      frame_body.delete();
      case ($urandom_range(3))
         0: begin
            frame_body.push_back(ADDR_BYTE);
            frame_body.push_back(CTRL_BYTE);
            frame_body.push_back(8'($urandom_range(255)) & 8'hFE);
            frame_body.push_back(8'($urandom_range(255)) | 8'h01);
         end
         1: begin
            frame_body.push_back(8'($urandom_range(255)) & 8'hFE);
            frame_body.push_back(8'($urandom_range(255)) | 8'h01);
         end
         2: begin
            frame_body.push_back(ADDR_BYTE);
            frame_body.push_back(CTRL_BYTE);
            frame_body.push_back(8'($urandom_range(255)) | 8'h01);
         end
         default: begin
            frame_body.push_back(8'($urandom_range(255)) | 8'h01);
         end
      endcase
      repeat (len) frame_body.push_back(pick_byte());
   endfunction

   // Appends the FCS, optionally flips one bit, then byte-stuffs and closes with a flag.
   function automatic void emit_frame(input bit corrupt);
      logic [15:0] acc;
      logic [7:0]  b;
      int unsigned k;
      acc = CRC_INIT;
      foreach (frame_body[i]) acc = fcs16_next(acc, frame_body[i]);
      acc = ~acc;
      frame_body.push_back(acc[7:0]);
      frame_body.push_back(acc[15:8]);
      if (corrupt) begin
         k = $urandom_range(frame_body.size() - 1);
         frame_body[k] = frame_body[k] ^ (8'h01 << $urandom_range(7));
      end
      foreach (frame_body[i]) begin
         b = frame_body[i];
         if (b == FLAG_BYTE || b == ESC_BYTE || (b < 8'h20 && $urandom_range(3) == 0)) begin
            link_bytes.push_back(ESC_BYTE);
            link_bytes.push_back(b ^ ESC_XOR);
         end else begin
            link_bytes.push_back(b);
         end
      end
      link_bytes.push_back(FLAG_BYTE);
   endfunction

   function automatic void emit_noise();
      case ($urandom_range(3))
         0: begin
            repeat ($urandom_range(1, 6)) link_bytes.push_back(pick_byte());
         end
         1: begin
            link_bytes.push_back(8'($urandom_range(255)));
            link_bytes.push_back(ESC_BYTE);
            link_bytes.push_back(ESC_BYTE);
            link_bytes.push_back(8'($urandom_range(255)));
         end
         2: begin
            link_bytes.push_back(8'($urandom_range(255)));
            link_bytes.push_back(ESC_BYTE);
         end
         default: begin
            link_bytes.push_back(FLAG_BYTE);
         end
      endcase
      link_bytes.push_back(FLAG_BYTE);
   endfunction

   function automatic void add_random_frames(input int unsigned upto);
      int unsigned pick;
      while (link_bytes.size() < upto) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            emit_noise();
         end else begin
            build_body($urandom_range(0, 10));
            emit_frame(pick == 1);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_decoder();
      end else begin
         if (req_valid && !req_stall) begin
            decode_link_byte(req_rx_byte);
            bytes_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (link_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_rx_byte <= link_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (bytes_accepted < total_bytes / 3) begin
            send_gap_pct <= 10;
            stall_pct <= 63;
         end else if (bytes_accepted < 2 * total_bytes / 3) begin
            send_gap_pct <= 63;
            stall_pct <= 10;
         end else begin
            send_gap_pct <= 0;
            stall_pct <= 0;
         end
      end
   end

   always @(posedge clock) begin
      rslt_type want;
      bit       bad;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("Unexpected result beat: kind=%0d byte=%h pos=%0d ok=%0d proto=%h last=%0d",
                           rsp_kind, rsp_byte_value, rsp_position, rsp_frame_ok,
                           rsp_protocol, rsp_last);
               end
            end else begin
               want = expected_beats.pop_front();
               bad = (rsp_kind != want.kind) || (rsp_byte_value != want.byte_value) ||
                     (rsp_position != want.position) || (rsp_frame_ok != want.frame_ok) ||
                     (rsp_protocol != want.protocol) || (rsp_last != want.last);
               if (bad) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display("Beat %0d mismatch: expected kind=%0d byte=%h pos=%0d ok=%0d proto=%h last=%0d",
                              beats_checked, want.kind, want.byte_value, want.position,
                              want.frame_ok, want.protocol, want.last);
                     $display("   got kind=%0d byte=%h pos=%0d ok=%0d proto=%h last=%0d",
                              rsp_kind, rsp_byte_value, rsp_position, rsp_frame_ok,
                              rsp_protocol, rsp_last);
                  end
               end
               if (want.kind == KIND_END) begin
                  frames_ended++;
                  if (want.frame_ok) begin
                     frames_good++;
                  end
               end
            end
            beats_checked++;
         end
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d beats outstanding.", cycle_count,
                  expected_beats.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int unsigned opening_end;
      foreach (OPENING[i]) link_bytes.push_back(OPENING[i]);
      frame_body = {ADDR_BYTE, CTRL_BYTE, 8'h00, 8'h21, 8'h45, FLAG_BYTE};
      emit_frame(1'b0);
      opening_end = link_bytes.size();
      add_random_frames(opening_end + RANDOM_BYTES / 4);
      // A frame longer than the buffer, so that surplus bytes are dropped.
      build_body(BUF_BYTES + 6);
      emit_frame(1'b0);
      add_random_frames(opening_end + RANDOM_BYTES);
      total_bytes = link_bytes.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted < total_bytes) @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (expected_beats.size() != 0) begin
         fail_count++;
         $display("%0d expected beats never arrived.", expected_beats.size());
      end
      $display("Sent %0d link bytes in three pacing phases; checked %0d result beats.",
               total_bytes, beats_checked);
      $display("Saw %0d frame ends, %0d with a good FCS, including an oversized frame.",
               frames_ended, frames_good);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/ppprx_pkg.sv
hdl/ppp_rx_deframer.sv
dv/tb_ppp_rx_deframer.sv
